// ===== src/pcdbd_pkg.sv =====
package pcdbd_pkg;

   // Widest row the line stores support; each store holds one entry per pixel pair.
   localparam int MAX_WIDTH    = 1024;
   localparam int LINE_DEPTH   = MAX_WIDTH / 2;
   localparam int ADDR_W       = $clog2(LINE_DEPTH);
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int HEIGHT_LIMIT = 1024;
   localparam int ROW_W        = $clog2(HEIGHT_LIMIT);

   // Configuration port.
   localparam int CFG_W     = 11;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;
   localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd320;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd240;
   localparam logic [CFG_W-1:0] EVEN_MASK    = 11'h7FE;

   // Payload widths.
   localparam int BYTE_W  = 8;
   localparam int PIXEL_W = 8;

   // Value of a line store entry that has not been written in this frame.
   localparam logic [PIXEL_W-1:0] LINE_INIT = 8'h80;

   // Prefix code patterns.
   localparam logic [7:0] CODE0_PAT = 8'h00;
   localparam logic [7:0] CODE1_PAT = 8'h02;
   localparam logic [7:0] CODE2_PAT = 8'h06;
   localparam logic [7:0] CODE3_PAT = 8'h0E;
   localparam logic [7:0] LONG_MAX  = 8'hFB;
   localparam logic [3:0] LONG_BASE = 4'd4;

   // Code translator and delta table.
   localparam logic [3:0] CODE_TO_DELTA [16] = '{
      4'd8, 4'd7, 4'd9, 4'd6, 4'd10, 4'd11, 4'd12, 4'd13,
      4'd14, 4'd15, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0
   };
   localparam logic signed [8:0] DELTA_VALUES [16] = '{
      -9'sd144, -9'sd110, -9'sd77, -9'sd53, -9'sd35, -9'sd21, -9'sd11, -9'sd3,
      9'sd2, 9'sd10, 9'sd20, 9'sd34, 9'sd52, 9'sd76, 9'sd110, 9'sd144
   };

   // Delta applied for a decoded code.
   function automatic logic signed [8:0] code_delta(input logic [3:0] code);
      return DELTA_VALUES[CODE_TO_DELTA[code]];
   endfunction

endpackage

// ===== src/pcdbd_if.sv =====
// Compressed byte channel.
interface pcdbd_req_if import pcdbd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   code_byte;
   logic                frame_start;

   modport source (output valid, output code_byte, output frame_start, input ready);
   modport sink   (input valid, input code_byte, input frame_start, output ready);
endinterface

// Decoded pixel channel.
interface pcdbd_rsp_if import pcdbd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PIXEL_W-1:0]  pixel;
   logic                frame_done;
   logic                bad_code;
   logic                last;

   modport source (output valid, output pixel, output frame_done, output bad_code,
                   output last, input ready);
   modport sink   (input valid, input pixel, input frame_done, input bad_code,
                   input last, output ready);
endinterface

// Register write channel.
interface pcdbd_csr_if import pcdbd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/prefix_code_dpcm_bayer_decoder.sv =====
// Each bit is examined in the decode state and each completed code moves to the prediction state;
// its pixel beat is registered there and presented in the cycle after the prediction fires.
// A new byte is taken only in the idle state, once the previous byte is finished: its bits are
// decoded in turn, each completed code gives a pixel or illegal-code beat, a frame end or an illegal
// code ends the byte early, a byte received while halted is dropped, and output stalls hold the flow.
// Reset is synchronous and sets the size to 320 x 240; fill counts mark the stores empty.
module prefix_code_dpcm_bayer_decoder import pcdbd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pcdbd_req_if.sink   req_if,
   pcdbd_rsp_if.source rsp_if,
   pcdbd_csr_if.sink   csr_if
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_BIT  = 2'd1;
   localparam logic [1:0] S_CALC = 2'd2;
   localparam logic [1:0] S_BAD  = 2'd3;

   localparam logic [1:0] ST_RED   = 2'd0;
   localparam logic [1:0] ST_GREEN = 2'd1;
   localparam logic [1:0] ST_BLUE  = 2'd2;

   localparam int USED_W = COL_W + 1;

   logic [1:0]          state_ff, state_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic [2:0]          bit_ff, bit_in;
   logic [7:0]          pcode_ff, pcode_in;
   logic [3:0]          plen_ff, plen_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [PIXEL_W-1:0]  prev_l_ff, prev_l_in;
   logic [PIXEL_W-1:0]  prev_r_ff, prev_r_in;
   logic [ADDR_W:0]     fill_r_ff, fill_r_in;
   logic [ADDR_W:0]     fill_g_ff, fill_g_in;
   logic [ADDR_W:0]     fill_b_ff, fill_b_in;
   logic                halted_ff, halted_in;
   logic [3:0]          code_ff, code_in;
   logic                more_ff, more_in;
   logic                hit_ff, hit_in;
   logic [CFG_W-1:0]    width_ff, width_in;
   logic [CFG_W-1:0]    height_ff, height_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0]  rsp_pixel_ff, rsp_pixel_in;
   logic                rsp_done_ff, rsp_done_in;
   logic                rsp_bad_ff, rsp_bad_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [PIXEL_W-1:0]  red_mem [LINE_DEPTH];
   logic [PIXEL_W-1:0]  green_mem [LINE_DEPTH];
   logic [PIXEL_W-1:0]  blue_mem [LINE_DEPTH];
   logic [PIXEL_W-1:0]  red_rd_ff, green_rd_ff, blue_rd_ff;

   logic                req_fire;
   logic                out_free;
   logic                rd_en;
   logic                wr_en;

   // Frame size in use: rounded down to even and clamped.
   logic [CFG_W-1:0]    width_even, height_even;
   logic [USED_W-1:0]   used_w;
   logic [CFG_W-1:0]    used_h;

   always_comb begin
      width_even  = width_ff & EVEN_MASK;
      height_even = height_ff & EVEN_MASK;
      if (width_even < CFG_W'(2)) begin
         used_w = USED_W'(2);
      end else if (32'(width_even) > MAX_WIDTH) begin
         used_w = USED_W'(MAX_WIDTH);
      end else begin
         used_w = USED_W'(width_even);
      end
      if (height_even < CFG_W'(2)) begin
         used_h = CFG_W'(2);
      end else if (32'(height_even) > HEIGHT_LIMIT) begin
         used_h = CFG_W'(HEIGHT_LIMIT);
      end else begin
         used_h = height_even;
      end
   end

   // Store selection and addressing for the current position.
   logic [ADDR_W-1:0]   pair;
   logic                left;
   logic                odd_row;
   logic [1:0]          store_sel;
   logic [ADDR_W-1:0]   rd_idx;
   logic                use_avg;
   logic [ADDR_W:0]     pair_next;
   logic [ADDR_W:0]     last_pair;
   logic [ADDR_W:0]     sel_fill;

   always_comb begin
      pair      = col_ff[COL_W-1:1];
      left      = !col_ff[0];
      odd_row   = row_ff[0];
      pair_next = {1'b0, pair} + 1'b1;
      last_pair = (ADDR_W + 1)'(used_w >> 1) - 1'b1;
      use_avg   = (pair != '0);
      rd_idx    = pair;
      if (!odd_row) begin
         if (left) begin
            store_sel = ST_RED;
         end else begin
            store_sel = ST_GREEN;
            if (pair == '0) begin
               rd_idx = ADDR_W'(1);
            end else if ({1'b0, pair} == last_pair) begin
               rd_idx = pair;
            end else if (32'(pair_next) >= LINE_DEPTH) begin
               rd_idx = ADDR_W'(LINE_DEPTH - 1);
            end else begin
               rd_idx = pair_next[ADDR_W-1:0];
            end
         end
      end else begin
         store_sel = left ? ST_GREEN : ST_BLUE;
      end
      case (store_sel)
         ST_RED:   sel_fill = fill_r_ff;
         ST_GREEN: sel_fill = fill_g_ff;
         default:  sel_fill = fill_b_ff;
      endcase
   end

   // Prefix decode of the next bit.
   logic                cur_bit;
   logic [7:0]          pcode_next;
   logic [3:0]          plen_next;
   logic                code_hit;
   logic                code_bad;
   logic [3:0]          code_val;
   logic                more_ahead;

   always_comb begin
      cur_bit    = byte_ff[bit_ff];
      pcode_next = {pcode_ff[6:0], cur_bit};
      plen_next  = plen_ff + 1'b1;
      code_hit   = 1'b1;
      code_bad   = 1'b0;
      code_val   = '0;
      if (plen_next == 4'd1 && pcode_next == CODE0_PAT) begin
         code_val = 4'd0;
      end else if (plen_next == 4'd2 && pcode_next == CODE1_PAT) begin
         code_val = 4'd1;
      end else if (plen_next == 4'd3 && pcode_next == CODE2_PAT) begin
         code_val = 4'd2;
      end else if (plen_next == 4'd4 && pcode_next == CODE3_PAT) begin
         code_val = 4'd3;
      end else if (plen_next >= 4'd8) begin
         if (pcode_next <= LONG_MAX) begin
            code_val = pcode_next[3:0] + LONG_BASE;
         end else begin
            code_hit = 1'b0;
            code_bad = 1'b1;
         end
      end else begin
         code_hit = 1'b0;
      end
      // A later code in this byte ends at a zero among the next four bits.
      more_ahead = 1'b0;
      for (int k = 1; k <= 4; k++) begin
         if (32'(bit_ff) >= k && !byte_ff[3'(32'(bit_ff) - k)]) begin
            more_ahead = 1'b1;
         end
      end
   end

   // Prediction: one shared add for the average, one for the delta, then clamp.
   logic [PIXEL_W-1:0]  rd_raw;
   logic [PIXEL_W-1:0]  rd_val;
   logic [PIXEL_W-1:0]  prev_val;
   logic [PIXEL_W:0]    avg_sum;
   logic [PIXEL_W-1:0]  base;
   logic signed [9:0]   sum_val;
   logic [PIXEL_W-1:0]  pix_val;

   always_comb begin
      case (store_sel)
         ST_RED:   rd_raw = red_rd_ff;
         ST_GREEN: rd_raw = green_rd_ff;
         default:  rd_raw = blue_rd_ff;
      endcase
      rd_val   = hit_ff ? rd_raw : LINE_INIT;
      prev_val = left ? prev_l_ff : prev_r_ff;
      avg_sum  = {1'b0, rd_val} + {1'b0, prev_val};
      base     = use_avg ? avg_sum[PIXEL_W:1] : rd_val;
      sum_val  = $signed({2'b00, base}) + 10'(code_delta(code_ff));
      if (sum_val < 0) begin
         pix_val = '0;
      end else if (sum_val > 10'sd255) begin
         pix_val = 8'hFF;
      end else begin
         pix_val = sum_val[PIXEL_W-1:0];
      end
   end

   // Position advance after a pixel.
   logic [USED_W-1:0]   col_step;
   logic [ROW_W:0]      row_step;
   logic                row_end;
   logic                frame_end;

   always_comb begin
      col_step  = {1'b0, col_ff} + 1'b1;
      row_step  = {1'b0, row_ff} + 1'b1;
      row_end   = (col_step >= used_w);
      frame_end = row_end && (CFG_W'(row_step) >= used_h);
   end

   assign req_fire      = req_if.valid && req_if.ready;
   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready  = (state_ff == S_IDLE);
   assign csr_if.ready  = 1'b1;
   assign rd_en         = (state_ff == S_BIT) && code_hit;
   assign wr_en         = (state_ff == S_CALC) && out_free;

   // Sequencer and decoder state.
   always_comb begin
      state_in     = state_ff;
      byte_in      = byte_ff;
      bit_in       = bit_ff;
      pcode_in     = pcode_ff;
      plen_in      = plen_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      prev_l_in    = prev_l_ff;
      prev_r_in    = prev_r_ff;
      fill_r_in    = fill_r_ff;
      fill_g_in    = fill_g_ff;
      fill_b_in    = fill_b_ff;
      halted_in    = halted_ff;
      code_in      = code_ff;
      more_in      = more_ff;
      hit_in       = hit_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_if.valid && csr_if.ready) begin
         unique case (csr_if.index)
            CSR_IMAGE_WIDTH:  width_in  = csr_if.data;
            CSR_IMAGE_HEIGHT: height_in = csr_if.data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               byte_in = req_if.code_byte;
               bit_in  = 3'd7;
               if (req_if.frame_start) begin
                  pcode_in  = '0;
                  plen_in   = '0;
                  col_in    = '0;
                  row_in    = '0;
                  prev_l_in = '0;
                  prev_r_in = '0;
                  fill_r_in = '0;
                  fill_g_in = '0;
                  fill_b_in = '0;
                  halted_in = 1'b0;
                  state_in  = S_BIT;
               end else if (!halted_ff) begin
                  state_in = S_BIT;
               end
            end
         end
         S_BIT: begin
            if (code_bad) begin
               pcode_in  = '0;
               plen_in   = '0;
               halted_in = 1'b1;
               state_in  = S_BAD;
            end else if (code_hit) begin
               pcode_in = '0;
               plen_in  = '0;
               code_in  = code_val;
               more_in  = more_ahead;
               hit_in   = ({1'b0, rd_idx} < sel_fill);
               state_in = S_CALC;
            end else begin
               pcode_in = pcode_next;
               plen_in  = plen_next;
               if (bit_ff == 3'd0) begin
                  state_in = S_IDLE;
               end else begin
                  bit_in = bit_ff - 1'b1;
               end
            end
         end
         S_CALC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = pix_val;
               rsp_done_in  = frame_end;
               rsp_bad_in   = 1'b0;
               rsp_last_in  = frame_end || !more_ff;
               if (left) begin
                  prev_l_in = pix_val;
               end else begin
                  prev_r_in = pix_val;
               end
               // Written entries always form a prefix of each store.
               case (store_sel)
                  ST_RED: begin
                     if ({1'b0, pair} >= fill_r_ff) fill_r_in = pair_next;
                  end
                  ST_GREEN: begin
                     if ({1'b0, pair} >= fill_g_ff) fill_g_in = pair_next;
                  end
                  default: begin
                     if ({1'b0, pair} >= fill_b_ff) fill_b_in = pair_next;
                  end
               endcase
               if (row_end) begin
                  col_in = '0;
                  row_in = row_step[ROW_W-1:0];
               end else begin
                  col_in = col_step[COL_W-1:0];
               end
               if (frame_end) begin
                  pcode_in  = '0;
                  plen_in   = '0;
                  col_in    = '0;
                  row_in    = '0;
                  prev_l_in = '0;
                  prev_r_in = '0;
                  fill_r_in = '0;
                  fill_g_in = '0;
                  fill_b_in = '0;
                  halted_in = 1'b0;
                  state_in  = S_IDLE;
               end else if (bit_ff == 3'd0) begin
                  state_in = S_IDLE;
               end else begin
                  bit_in   = bit_ff - 1'b1;
                  state_in = S_BIT;
               end
            end
         end
         S_BAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = '0;
               rsp_done_in  = 1'b0;
               rsp_bad_in   = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pcode_ff     <= '0;
         plen_ff      <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         prev_l_ff    <= '0;
         prev_r_ff    <= '0;
         fill_r_ff    <= '0;
         fill_g_ff    <= '0;
         fill_b_ff    <= '0;
         halted_ff    <= 1'b0;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pcode_ff     <= pcode_in;
         plen_ff      <= plen_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         prev_l_ff    <= prev_l_in;
         prev_r_ff    <= prev_r_in;
         fill_r_ff    <= fill_r_in;
         fill_g_ff    <= fill_g_in;
         fill_b_ff    <= fill_b_in;
         halted_ff    <= halted_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      bit_ff       <= bit_in;
      code_ff      <= code_in;
      more_ff      <= more_in;
      hit_ff       <= hit_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_bad_ff   <= rsp_bad_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Line stores: one registered read and one write per pixel.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         red_rd_ff   <= red_mem[rd_idx];
         green_rd_ff <= green_mem[rd_idx];
         blue_rd_ff  <= blue_mem[rd_idx];
      end
      if (wr_en && store_sel == ST_RED) begin
         red_mem[pair] <= pix_val;
      end
      if (wr_en && store_sel == ST_GREEN) begin
         green_mem[pair] <= pix_val;
      end
      if (wr_en && store_sel == ST_BLUE) begin
         blue_mem[pair] <= pix_val;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.pixel      = rsp_pixel_ff;
   assign rsp_if.frame_done = rsp_done_ff;
   assign rsp_if.bad_code   = rsp_bad_ff;
   assign rsp_if.last       = rsp_last_ff;

   // An illegal code beat carries no pixel and closes its byte.
   a_bad_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bad_ff |-> rsp_pixel_ff == '0 && rsp_last_ff && !rsp_done_ff)
      else $error("bad code beat has wrong fields");

   // The frame position is back at the origin once the final pixel is out.
   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> col_ff == '0 && row_ff == '0)
      else $error("position not cleared after frame end");

   // The prediction cycle always follows a completed code.
   a_calc_partial: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CALC |-> plen_ff == '0 && pcode_ff == '0)
      else $error("partial code left over in prediction");

   // A halted decoder only reports the bad code or waits for a new frame.
   a_halted: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> state_ff == S_IDLE || state_ff == S_BAD)
      else $error("decoder running while halted");

   // Fill counts never pass the store depth.
   a_fill: assert property (@(posedge clock) disable iff (reset)
      32'(fill_r_ff) <= LINE_DEPTH && 32'(fill_g_ff) <= LINE_DEPTH
      && 32'(fill_b_ff) <= LINE_DEPTH)
      else $error("line store fill count out of range");

endmodule
